@@ sv/assert_macros.svh @@
// assertion macros shared by the timed wait queue modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define TWQ_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TWQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/twq_pkg.sv @@
// types and codes of the timed wait queue
// used by front end, command queue, back end and top level; no dependencies
package twq_pkg;

	localparam int ID_W   = 16;
	localparam int TMO_W  = 16;
	localparam int REQ_W  = 3;
	localparam int STAT_W = 3;
	localparam int QCNT_W = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REM_HEAD  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REM_ID    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK      = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_TICK_DONE = 3'd5;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REM_HEAD,
		OP_REM_ID,
		OP_LOOKUP,
		OP_TICK,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [TMO_W-1:0] wt;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TMO_W-1:0] tmo;
	} entry_t;

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

endpackage

@@ sv/twq_front.sv @@
// request front end: registers and classifies incoming words into commands
// depends on twq_pkg; feeds twq_cmd_fifo
module twq_front import twq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ID_W-1:0]   proc_id,
	input  logic [TMO_W-1:0]  wait_time,
	input  q_flags_t          qf,
	output logic              q_push,
	output cmd_t              q_cmd
);

	logic vld_s1;
	cmd_t cmd_s1;
	op_t  op_dec;

	always_comb begin
		case (req_type)
			REQ_INSERT:   op_dec = OP_INSERT;
			REQ_REM_HEAD: op_dec = OP_REM_HEAD;
			REQ_REM_ID:   op_dec = OP_REM_ID;
			REQ_LOOKUP:   op_dec = OP_LOOKUP;
			REQ_TICK:     op_dec = OP_TICK;
			default:      op_dec = OP_NOP;
		endcase
	end

	assign req_stall = vld_s1 && qf.full;
	assign q_push    = vld_s1 && !qf.full;
	assign q_cmd     = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1 <= '{op: op_dec, id: proc_id, wt: wait_time};
		end
	end

endmodule

@@ sv/twq_cmd_fifo.sv @@
// short command queue decoupling front end and back end
// depends on twq_pkg and assert_macros.svh
`include "assert_macros.svh"
module twq_cmd_fifo import twq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cmd_t     push_cmd,
	input  logic     pop,
	output cmd_t     head,
	output q_flags_t qf
);

	cmd_t            slot_q [QDEPTH];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [QCW-1:0]  cnt_q;

	assign qf.full  = (cnt_q == QCW'(QDEPTH));
	assign qf.empty = (cnt_q == '0);
	assign head     = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	`TWQ_ASSERT_IMPLY(a_no_pop_empty, pop, !qf.empty, "pop from empty command queue")
	`TWQ_ASSERT_IMPLY(a_no_push_full, push && !pop, !qf.full, "push into full command queue")
	`TWQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCW'(QDEPTH), "command queue count overflow")

endmodule

@@ sv/twq_back.sv @@
// back end: entry memory, walk sequencer and result register
// depends on twq_pkg and assert_macros.svh; takes commands from twq_cmd_fifo
`include "assert_macros.svh"
module twq_back import twq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  q_flags_t          qf,
	input  cmd_t              head,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   out_id,
	output logic              found,
	output logic              release_credit,
	output logic [QCNT_W-1:0] queue_count,
	output logic              last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	back_state_t state_q, state_d;

	entry_t          mem [DEPTH];
	entry_t          rdata_s1;
	logic            v_s1;
	logic            first_s1;

	cmd_t            cur_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   total_q;
	logic [CW-1:0]   rd_q;
	logic [CW-1:0]   wr_q;
	logic            matched_q;
	logic [ID_W-1:0] hit_id_q;
	logic            sem_q;

	logic            ov_q;
	logic [STAT_W-1:0] stat_q;
	logic [ID_W-1:0] id_q;
	logic            found_q;
	logic            credit_q;
	logic [QCNT_W-1:0] qcnt_q;
	logic            last_q;

	logic            out_free;
	logic            take;
	logic            starts_walk;
	logic            walk_done;

	logic            emit;
	logic [STAT_W-1:0] r_stat;
	logic [ID_W-1:0] r_id;
	logic            r_found;
	logic            r_credit;
	logic [CW-1:0]   r_cnt;
	logic            r_last;
	logic            we;
	logic [AW-1:0]   waddr;
	entry_t          wdata;
	logic            ren;
	logic            drop;
	logic            hit;
	logic            cnt_inc;
	logic [TMO_W-1:0] newt;

	assign out_free    = !ov_q || !rsp_stall;
	assign take        = (state_q == BK_IDLE) && !qf.empty && out_free;
	assign starts_walk = (head.op == OP_REM_ID) || (head.op == OP_LOOKUP) ||
		(head.op == OP_TICK) || ((head.op == OP_REM_HEAD) && (cnt_q != '0));
	assign walk_done   = (state_q == BK_WALK) && out_free && !v_s1 && (rd_q == total_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take && starts_walk) begin
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (walk_done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		emit     = 1'b0;
		r_stat   = ST_OK;
		r_id     = '0;
		r_found  = 1'b0;
		r_credit = 1'b0;
		r_cnt    = cnt_q;
		r_last   = 1'b1;
		we       = 1'b0;
		waddr    = wr_q[AW-1:0];
		wdata    = rdata_s1;
		ren      = 1'b0;
		drop     = 1'b0;
		hit      = 1'b0;
		cnt_inc  = 1'b0;
		newt     = rdata_s1.tmo;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					case (head.op)
						OP_INSERT: begin
							emit = 1'b1;
							if (cnt_q == DEPTH_C) begin
								r_stat = ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = cnt_q[AW-1:0];
								wdata   = '{id: head.id, tmo: head.wt};
								cnt_inc = 1'b1;
								r_cnt   = CW'(cnt_q + 1'b1);
							end
						end
						OP_REM_HEAD: begin
							if (cnt_q == '0) begin
								emit   = 1'b1;
								r_stat = ST_EMPTY;
							end
						end
						OP_REM_ID, OP_LOOKUP, OP_TICK: begin
						end
						default: emit = 1'b1;
					endcase
				end
			end
			BK_WALK: begin
				if (out_free) begin
					ren = (rd_q < total_q);
					if (v_s1) begin
						case (cur_q.op)
							OP_REM_HEAD: begin
								drop = first_s1;
								hit  = first_s1;
							end
							OP_REM_ID: begin
								drop = !matched_q && (rdata_s1.id == cur_q.id);
								hit  = drop;
							end
							OP_LOOKUP: begin
								hit = !matched_q && (rdata_s1.id == cur_q.id);
							end
							OP_TICK: begin
								if (rdata_s1.tmo != '0) begin
									newt = rdata_s1.tmo - 1'b1;
									if (newt == '0) begin
										drop     = 1'b1;
										emit     = 1'b1;
										r_stat   = ST_EXPIRED;
										r_id     = rdata_s1.id;
										r_found  = 1'b1;
										r_credit = sem_q;
										r_cnt    = CW'(cnt_q - 1'b1);
										r_last   = 1'b0;
									end
								end
							end
							default: begin
							end
						endcase
						if (!drop) begin
							we    = 1'b1;
							waddr = wr_q[AW-1:0];
							wdata = '{id: rdata_s1.id, tmo: newt};
						end
					end else if (rd_q == total_q) begin
						emit = 1'b1;
						if (cur_q.op == OP_TICK) begin
							r_stat = ST_TICK_DONE;
						end else if (matched_q) begin
							r_id    = hit_id_q;
							r_found = 1'b1;
						end else begin
							r_stat = ST_NOT_FOUND;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_s1 <= mem[rd_q[AW-1:0]];
			first_s1 <= (rd_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cnt_q     <= '0;
			total_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			v_s1      <= 1'b0;
			matched_q <= 1'b0;
			sem_q     <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sem_q <= cfg_wdata;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (drop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (take) begin
				total_q   <= cnt_q;
				rd_q      <= '0;
				wr_q      <= '0;
				v_s1      <= 1'b0;
				matched_q <= 1'b0;
			end else if ((state_q == BK_WALK) && out_free) begin
				v_s1 <= ren;
				if (ren) begin
					rd_q <= rd_q + 1'b1;
				end
				if (v_s1 && !drop) begin
					wr_q <= wr_q + 1'b1;
				end
				if (hit) begin
					matched_q <= 1'b1;
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!rsp_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= head;
		end
		if (hit) begin
			hit_id_q <= rdata_s1.id;
		end
		if (emit) begin
			stat_q   <= r_stat;
			id_q     <= r_id;
			found_q  <= r_found;
			credit_q <= r_credit;
			qcnt_q   <= QCNT_W'(r_cnt);
			last_q   <= r_last;
		end
	end

	assign rsp_valid      = ov_q;
	assign status         = stat_q;
	assign out_id         = id_q;
	assign found          = found_q;
	assign release_credit = credit_q;
	assign queue_count    = qcnt_q;
	assign last           = last_q;

	`TWQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= DEPTH_C, "entry count above depth")
	`TWQ_ASSERT_IMPLY(a_wr_behind_rd, state_q == BK_WALK, wr_q <= rd_q, "compaction overtook reads")
	`TWQ_ASSERT_NEXT(a_walk_ends_last, walk_done, rsp_valid && last, "walk ended without last result")

endmodule

@@ sv/timed_wait_queue.sv @@
// timed wait queue top level: front end, command queue and back end
// depends on twq_pkg, twq_front, twq_cmd_fifo and twq_back
//
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  req_type, proc_id, wait_time
// response  out        rsp_valid / rsp_stall  status, out_id, found, release_credit,
//                                             queue_count, last
// config    in         cfg_we                 cfg_wdata (semaphore attached)
//
// insert, remove head on an empty queue and unused codes are answered from the idle state.
// remove id, lookup, tick and remove head walk the entries: the command is taken, then
// one entry per cycle is read through the entry memory's single read port while the
// output is free, the read data is registered, and a final result word ends the walk.
// the front end registers each request word; two commands may wait between the parts.
// reset clears counts and control only; entry memory needs no clearing. with a response
// held, rsp_stall freezes the back end; req_stall rises when a word meets a full queue.
module timed_wait_queue import twq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ID_W-1:0]   proc_id,
	input  logic [TMO_W-1:0]  wait_time,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   out_id,
	output logic              found,
	output logic              release_credit,
	output logic [QCNT_W-1:0] queue_count,
	output logic              last
);

	q_flags_t qf;
	logic     q_push;
	logic     q_pop;
	cmd_t     q_cmd;
	cmd_t     q_head;

	twq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.proc_id   (proc_id),
		.wait_time (wait_time),
		.qf        (qf),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	twq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.qf       (qf)
	);

	twq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.qf             (qf),
		.head           (q_head),
		.q_pop          (q_pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.out_id         (out_id),
		.found          (found),
		.release_credit (release_credit),
		.queue_count    (queue_count),
		.last           (last)
	);

endmodule

@@ bench/tb_timed_wait_queue.sv @@
// testbench for timed_wait_queue: a directed table, random words, a fill and expiry phase, then more random words
// every response word is checked against a queue predictor kept inside the bench
// depends on twq_pkg and the timed_wait_queue rtl
module tb_timed_wait_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import twq_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;
	localparam int DIR_N = 21;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   out_id;
		logic              found;
		logic              credit;
		logic [QCNT_W-1:0] count;
		logic              last;
	} rsp_word_t;

	typedef struct {
		logic [REQ_W-1:0]  rq;
		logic [ID_W-1:0]   pid;
		logic [TMO_W-1:0]  wt;
		bit                typed;
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   out_id;
	} dir_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              req_valid;
	logic              req_stall;
	logic [REQ_W-1:0]  req_type;
	logic [ID_W-1:0]   proc_id;
	logic [TMO_W-1:0]  wait_time;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   out_id;
	logic              found;
	logic              release_credit;
	logic [QCNT_W-1:0] queue_count;
	logic              last;

	// shadow copy of the queue contents and the register
	logic [ID_W-1:0]  shadow_ids [DEPTH];
	logic [TMO_W-1:0] shadow_tmo [DEPTH];
	int               shadow_count = 0;
	logic             shadow_sem = 1'b0;

	rsp_word_t pending_rsp [$];
	int        fail_count = 0;
	int        words_sent = 0;
	int        words_seen = 0;
	int        expiries_seen = 0;
	int        full_seen = 0;
	int        credits_seen = 0;
	int        stall_run = 0;
	bit        idling_on = 1'b1;

	dir_word_t dir_table [DIR_N] = '{
		'{REQ_REM_HEAD, 16'h0000, 16'h0000, 1'b1, ST_EMPTY,     16'h0000},
		'{REQ_LOOKUP,   16'hFFFF, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000},
		'{REQ_REM_ID,   16'h0000, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000},
		'{REQ_TICK,     16'h0000, 16'h0000, 1'b1, ST_TICK_DONE, 16'h0000},
		'{REQ_SPARE_A,  16'hFFFF, 16'hFFFF, 1'b1, ST_OK,        16'h0000},
		'{REQ_SPARE_B,  16'h0000, 16'h0000, 1'b1, ST_OK,        16'h0000},
		'{REQ_SPARE_C,  16'hFFFF, 16'hFFFF, 1'b1, ST_OK,        16'h0000},
		'{REQ_INSERT,   16'h0000, 16'h0000, 1'b1, ST_OK,        16'h0000},
		'{REQ_INSERT,   16'hFFFF, 16'hFFFF, 1'b1, ST_OK,        16'h0000},
		'{REQ_INSERT,   16'h1234, 16'h0001, 1'b1, ST_OK,        16'h0000},
		'{REQ_INSERT,   16'h1234, 16'h0002, 1'b1, ST_OK,        16'h0000},
		'{REQ_INSERT,   16'h00AA, 16'h0001, 1'b1, ST_OK,        16'h0000},
		'{REQ_LOOKUP,   16'h1234, 16'h0000, 1'b1, ST_OK,        16'h1234},
		'{REQ_LOOKUP,   16'h0000, 16'h0000, 1'b1, ST_OK,        16'h0000},
		'{REQ_TICK,     16'h0000, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_LOOKUP,   16'h00AA, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_REM_ID,   16'h1234, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_REM_ID,   16'hFFFF, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_REM_HEAD, 16'h0000, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_REM_HEAD, 16'h0000, 16'h0000, 1'b0, ST_OK,        16'h0000},
		'{REQ_TICK,     16'h0000, 16'h0000, 1'b0, ST_OK,        16'h0000}
	};

	timed_wait_queue #(.DEPTH(DEPTH)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.proc_id        (proc_id),
		.wait_time      (wait_time),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.out_id         (out_id),
		.found          (found),
		.release_credit (release_credit),
		.queue_count    (queue_count),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void push_rsp(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] oid,
			input logic fnd, input logic crd, input logic lst);
		rsp_word_t w;
		w.status = st;
		w.out_id = oid;
		w.found  = fnd;
		w.credit = crd;
		w.count  = QCNT_W'(shadow_count);
		w.last   = lst;
		pending_rsp.push_back(w);
	endfunction

	function automatic int find_entry(input logic [ID_W-1:0] pid);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_ids[i] == pid)
				return i;
		end
		return -1;
	endfunction

	function automatic void drop_entry(input int pos);
		for (int i = pos; i + 1 < shadow_count; i++) begin
			shadow_ids[i] = shadow_ids[i + 1];
			shadow_tmo[i] = shadow_tmo[i + 1];
		end
		shadow_count--;
	endfunction

	// expected response words of one accepted request word
	function automatic void predict_queue_op(input logic [REQ_W-1:0] rq,
			input logic [ID_W-1:0] pid, input logic [TMO_W-1:0] wt);
		int pos;
		int w;
		int total;
		logic [TMO_W-1:0] t;
		logic [ID_W-1:0] eid;
		case (rq)
			REQ_INSERT: begin
				if (shadow_count >= DEPTH) begin
					push_rsp(ST_FULL, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					shadow_ids[shadow_count] = pid;
					shadow_tmo[shadow_count] = wt;
					shadow_count++;
					push_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
				end
			end
			REQ_REM_HEAD: begin
				if (shadow_count == 0) begin
					push_rsp(ST_EMPTY, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					eid = shadow_ids[0];
					drop_entry(0);
					push_rsp(ST_OK, eid, 1'b1, 1'b0, 1'b1);
				end
			end
			REQ_REM_ID, REQ_LOOKUP: begin
				pos = find_entry(pid);
				if (pos < 0) begin
					push_rsp(ST_NOT_FOUND, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					if (rq == REQ_REM_ID)
						drop_entry(pos);
					push_rsp(ST_OK, pid, 1'b1, 1'b0, 1'b1);
				end
			end
			REQ_TICK: begin
				total = shadow_count;
				w = 0;
				for (int i = 0; i < total; i++) begin
					t = shadow_tmo[i];
					eid = shadow_ids[i];
					if (t != '0) begin
						t--;
						if (t == '0) begin
							shadow_count--;
							push_rsp(ST_EXPIRED, eid, 1'b1, shadow_sem, 1'b0);
							continue;
						end
					end
					shadow_ids[w] = eid;
					shadow_tmo[w] = t;
					w++;
				end
				shadow_count = w;
				push_rsp(ST_TICK_DONE, '0, 1'b0, 1'b0, 1'b1);
			end
			default: begin
				push_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	function automatic void pick_request(output logic [REQ_W-1:0] rq,
			output logic [ID_W-1:0] pid, output logic [TMO_W-1:0] wt);
		int k;
		k = $urandom_range(0, 99);
		if (k < 35)
			rq = REQ_INSERT;
		else if (k < 60)
			rq = REQ_TICK;
		else if (k < 72)
			rq = REQ_LOOKUP;
		else if (k < 84)
			rq = REQ_REM_ID;
		else if (k < 94)
			rq = REQ_REM_HEAD;
		else
			rq = REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
		k = $urandom_range(0, 99);
		if (k < 50 && shadow_count > 0)
			pid = shadow_ids[$urandom_range(0, shadow_count - 1)];
		else if (k < 80)
			pid = ID_W'($urandom_range(1, 8));
		else
			pid = ID_W'($urandom);
		k = $urandom_range(0, 99);
		if (k < 10)
			wt = '0;
		else if (k < 75)
			wt = TMO_W'($urandom_range(1, 12));
		else if (k < 95)
			wt = TMO_W'($urandom);
		else
			wt = '1;
	endfunction

	function automatic void check_field(input string fname, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", fname, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// one request word; typed rows replace the predicted status and id of the final word
	task automatic send_request(input logic [REQ_W-1:0] rq, input logic [ID_W-1:0] pid,
			input logic [TMO_W-1:0] wt, input bit typed, input logic [STAT_W-1:0] st,
			input logic [ID_W-1:0] oid);
		req_valid <= 1'b1;
		req_type  <= rq;
		proc_id   <= pid;
		wait_time <= wt;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_queue_op(rq, pid, wt);
		if (typed) begin
			pending_rsp[pending_rsp.size() - 1].status = st;
			pending_rsp[pending_rsp.size() - 1].out_id = oid;
		end
		words_sent++;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic settle_queue();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_semaphore(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		shadow_sem = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic empty_by_head();
		while (shadow_count > 0)
			send_request(REQ_REM_HEAD, '0, '0, 1'b0, ST_OK, '0);
		send_request(REQ_REM_HEAD, '0, '0, 1'b0, ST_OK, '0);
	endtask

	// response checker and stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				words_seen++;
				if (status == ST_EXPIRED)
					expiries_seen++;
				if (status == ST_FULL)
					full_seen++;
				if (release_credit)
					credits_seen++;
				if (pending_rsp.size() == 0) begin
					$error("response word with no prediction: status %0d id %0h", status, out_id);
					fail_count++;
				end else begin
					check_field("status", 16'(pending_rsp[0].status), 16'(status));
					check_field("out_id", pending_rsp[0].out_id, out_id);
					check_field("found", 16'(pending_rsp[0].found), 16'(found));
					check_field("release_credit", 16'(pending_rsp[0].credit),
						16'(release_credit));
					check_field("queue_count", 16'(pending_rsp[0].count), 16'(queue_count));
					check_field("last", 16'(pending_rsp[0].last), 16'(last));
					void'(pending_rsp.pop_front());
				end
			end
			if (!idling_on) begin
				rsp_stall <= 1'b0;
			end else if (stall_run > 0) begin
				stall_run--;
			end else if ($urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				stall_run = $urandom_range(0, 16);
			end else begin
				rsp_stall <= 1'b0;
				stall_run = $urandom_range(0, 29);
			end
		end
	end

	initial begin
		logic [REQ_W-1:0] rq;
		logic [ID_W-1:0]  pid;
		logic [TMO_W-1:0] wt;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		req_valid = 1'b0;
		req_type  = '0;
		proc_id   = '0;
		wait_time = '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_request(dir_table[i].rq, dir_table[i].pid, dir_table[i].wt,
				dir_table[i].typed, dir_table[i].status, dir_table[i].out_id);

		settle_queue();
		set_semaphore(1'b1);
		repeat (12) begin
			pick_request(rq, pid, wt);
			send_request(rq, pid, wt, 1'b0, ST_OK, '0);
		end

		// full queue with unit timeouts, so a single tick expires every entry
		settle_queue();
		set_semaphore(1'b0);
		empty_by_head();
		while (shadow_count < DEPTH)
			send_request(REQ_INSERT, ID_W'($urandom), TMO_W'(1), 1'b0, ST_OK, '0);
		send_request(REQ_INSERT, '1, '1, 1'b0, ST_OK, '0);
		send_request(REQ_TICK, '0, '0, 1'b0, ST_OK, '0);
		while (shadow_count < DEPTH)
			send_request(REQ_INSERT, ID_W'($urandom_range(1, 8)),
				($urandom_range(0, 4) == 0) ? '0 : TMO_W'($urandom_range(1, 10)),
				1'b0, ST_OK, '0);
		repeat (2)
			send_request(REQ_INSERT, ID_W'($urandom), TMO_W'($urandom), 1'b0, ST_OK, '0);
		repeat (12)
			send_request(REQ_TICK, '0, '0, 1'b0, ST_OK, '0);

		settle_queue();
		set_semaphore(1'b1);
		empty_by_head();
		repeat (12) begin
			pick_request(rq, pid, wt);
			send_request(rq, pid, wt, 1'b0, ST_OK, '0);
		end

		settle_queue();
		idling_on = 1'b0;
		repeat (14) begin
			pick_request(rq, pid, wt);
			send_request(rq, pid, wt, 1'b0, ST_OK, '0);
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d predicted response words never arrived", pending_rsp.size());
			fail_count++;
		end
		$display("ran %0d request words and checked %0d response words", words_sent, words_seen);
		$display("saw %0d expiries, %0d with credit, %0d full rejects", expiries_seen,
			credits_seen, full_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
